/* hw/rtl/rtt_pkg.sv */
// shared types, sizes and codes for the round transition table
package rtt_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned HalfW      = 32;
  localparam int unsigned RoundW     = 2 * HalfW;
  localparam int unsigned StatusW    = 4;
  localparam int unsigned PendW      = 5;

  typedef logic [RoundW-1:0] round_t;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_SNAPSHOT = 2'd1,
    REQ_CLEAR    = 2'd2
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_REGISTERED   = 4'd0,
    ST_DUP_REGISTER = 4'd1,
    ST_INVALID      = 4'd2,
    ST_APPLIED      = 4'd3,
    ST_ALREADY_CUR  = 4'd4,
    ST_STALE        = 4'd5,
    ST_MISSING      = 4'd6,
    ST_DUP_SNAPSHOT = 4'd7,
    ST_CLEARED      = 4'd8
  } status_e;

  // update request from the control logic to the entry store
  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_slot;
    round_t          wr_old;
    round_t          wr_next;
    logic            consume;
    logic            clear;
  } tbl_cmd_t;

  // lookup answer from the entry store
  typedef struct packed {
    logic                  hit;
    logic                  hit_consumed;
    round_t                hit_next;
    logic [MaxEntries-1:0] consumed;
  } tbl_rsp_t;

endpackage

/* hw/rtl/rtt_table.sv */
// associative entry store: old round keys, next rounds, valid and consumed flags
module rtt_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rtt_pkg::round_t  key_i,
  input  rtt_pkg::tbl_cmd_t cmd_i,
  output rtt_pkg::tbl_rsp_t rsp_o
);

  rtt_pkg::round_t                old_q  [rtt_pkg::MaxEntries];
  rtt_pkg::round_t                next_q [rtt_pkg::MaxEntries];
  logic [rtt_pkg::MaxEntries-1:0] valid_q, valid_d;
  logic [rtt_pkg::MaxEntries-1:0] consumed_q, consumed_d;
  logic [rtt_pkg::MaxEntries-1:0] match;
  rtt_pkg::round_t                sel_next;

  // keys are unique among valid entries, so at most one match bit is set
  always_comb begin
    sel_next = '0;
    for (int unsigned i = 0; i < rtt_pkg::MaxEntries; i++) begin
      match[i] = valid_q[i] && (old_q[i] == key_i);
      sel_next = sel_next | (match[i] ? next_q[i] : '0);
    end
  end

  always_comb begin
    rsp_o.hit          = |match;
    rsp_o.hit_consumed = |(match & consumed_q);
    rsp_o.hit_next     = sel_next;
    rsp_o.consumed     = consumed_q;
  end

  always_comb begin
    valid_d    = valid_q;
    consumed_d = consumed_q;
    if (cmd_i.clear) begin
      valid_d    = '0;
      consumed_d = '0;
    end else begin
      if (cmd_i.consume) begin
        consumed_d = consumed_q | match;
      end
      if (cmd_i.wr_en) begin
        valid_d[cmd_i.wr_slot]    = 1'b1;
        consumed_d[cmd_i.wr_slot] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      consumed_q <= '0;
    end else begin
      valid_q    <= valid_d;
      consumed_q <= consumed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      old_q[cmd_i.wr_slot]  <= cmd_i.wr_old;
      next_q[cmd_i.wr_slot] <= cmd_i.wr_next;
    end
  end

endmodule

/* hw/rtl/round_transition_table_top.sv */
// top level of the round transition table: input register, classification, result register
//
// every word is taken at a rising edge with start high and busy low; busy is never raised,
// so a word can be issued in every cycle. each word gives exactly one result, shown on the
// result ports for one cycle with done_o high: the word is held in the input register while
// the associative match over all sixteen entries and the classification feed the result
// register, which then takes the result. the receiver cannot hold results off, so
// results must be taken when done_o is high. table state is updated at the same edge that
// loads the result, so a word issued right behind another already sees its effect.
module round_transition_table_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type_i,
  input  logic [rtt_pkg::HalfW-1:0]    old_session_i,
  input  logic [rtt_pkg::HalfW-1:0]    old_generation_i,
  input  logic [rtt_pkg::HalfW-1:0]    new_session_i,
  input  logic [rtt_pkg::HalfW-1:0]    new_generation_i,
  output logic                         done_o,
  output logic [rtt_pkg::StatusW-1:0]  status_o,
  output logic                         exact_match_o,
  output logic                         allow_old_dir_o,
  output logic                         should_apply_o,
  output logic [rtt_pkg::HalfW-1:0]    next_session_out_o,
  output logic [rtt_pkg::HalfW-1:0]    next_generation_out_o,
  output logic [rtt_pkg::PendW-1:0]    pending_count_o
);

  localparam int unsigned SumW = rtt_pkg::CntW + 1;

  // input register
  logic                  in_vld_q;
  logic [1:0]            req_q;
  rtt_pkg::round_t       old_r_q;
  rtt_pkg::round_t       new_r_q;

  // ring and target state
  logic [rtt_pkg::IdxW-1:0] oldest_q, oldest_d;
  logic [rtt_pkg::CntW-1:0] count_q, count_d;
  logic [rtt_pkg::CntW-1:0] pend_q, pend_d;
  logic                     has_tgt_q, has_tgt_d;
  rtt_pkg::round_t          tgt_q, tgt_d;

  // result register
  logic                         done_q;
  rtt_pkg::status_e             status_q, status_d;
  logic                         exact_q, exact_d;
  logic                         allow_q, allow_d;
  logic                         apply_q, apply_d;
  rtt_pkg::round_t              nxt_q, nxt_d;
  logic [rtt_pkg::PendW-1:0]    pend_out_q;

  rtt_pkg::tbl_cmd_t        cmd;
  rtt_pkg::tbl_rsp_t        rsp;

  logic                     old_ok, new_ok, full;
  logic [SumW-1:0]          slot_sum;
  logic [rtt_pkg::IdxW-1:0] free_slot, wr_slot;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q   <= req_type_i;
      old_r_q <= {old_session_i, old_generation_i};
      new_r_q <= {new_session_i, new_generation_i};
    end
  end

  rtt_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (old_r_q),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  // a round is valid when both halves are nonzero
  assign old_ok = (|old_r_q[rtt_pkg::RoundW-1:rtt_pkg::HalfW]) && (|old_r_q[rtt_pkg::HalfW-1:0]);
  assign new_ok = (|new_r_q[rtt_pkg::RoundW-1:rtt_pkg::HalfW]) && (|new_r_q[rtt_pkg::HalfW-1:0]);
  assign full   = (count_q == rtt_pkg::CntW'(rtt_pkg::MaxEntries));

  // next free slot: oldest plus count, wrapped once around the ring
  assign slot_sum  = SumW'(oldest_q) + SumW'(count_q);
  assign free_slot = (slot_sum >= SumW'(rtt_pkg::MaxEntries))
                   ? rtt_pkg::IdxW'(slot_sum - SumW'(rtt_pkg::MaxEntries))
                   : rtt_pkg::IdxW'(slot_sum);
  assign wr_slot   = full ? oldest_q : free_slot;

  always_comb begin
    cmd         = '0;
    cmd.wr_slot = wr_slot;
    cmd.wr_old  = old_r_q;
    cmd.wr_next = new_r_q;

    oldest_d  = oldest_q;
    count_d   = count_q;
    pend_d    = pend_q;
    has_tgt_d = has_tgt_q;
    tgt_d     = tgt_q;

    status_d = rtt_pkg::ST_INVALID;
    exact_d  = 1'b0;
    allow_d  = 1'b0;
    apply_d  = 1'b0;
    nxt_d    = '0;

    if (in_vld_q) begin
      case (req_q)
        rtt_pkg::REQ_REGISTER: begin
          if (!old_ok || !new_ok || !(old_r_q < new_r_q)) begin
            status_d = rtt_pkg::ST_INVALID;
          end else if (rsp.hit) begin
            status_d = rtt_pkg::ST_DUP_REGISTER;
          end else begin
            status_d  = rtt_pkg::ST_REGISTERED;
            cmd.wr_en = 1'b1;
            if (full) begin
              // evict the oldest entry; pending only grows if it was already consumed
              oldest_d = (oldest_q == rtt_pkg::IdxW'(rtt_pkg::MaxEntries - 1))
                       ? '0 : oldest_q + 1'b1;
              if (rsp.consumed[oldest_q]) begin
                pend_d = pend_q + 1'b1;
              end
            end else begin
              count_d = count_q + 1'b1;
              pend_d  = pend_q + 1'b1;
            end
          end
        end
        rtt_pkg::REQ_SNAPSHOT: begin
          if (!old_ok) begin
            status_d = rtt_pkg::ST_INVALID;
          end else if (rsp.hit) begin
            exact_d = 1'b1;
            nxt_d   = rsp.hit_next;
            if (rsp.hit_consumed) begin
              status_d = rtt_pkg::ST_DUP_SNAPSHOT;
            end else begin
              cmd.consume = 1'b1;
              allow_d     = 1'b1;
              pend_d      = pend_q - 1'b1;
              if (!has_tgt_q || (tgt_q < rsp.hit_next)) begin
                status_d  = rtt_pkg::ST_APPLIED;
                apply_d   = 1'b1;
                has_tgt_d = 1'b1;
                tgt_d     = rsp.hit_next;
              end else if (tgt_q == rsp.hit_next) begin
                status_d = rtt_pkg::ST_ALREADY_CUR;
              end else begin
                status_d = rtt_pkg::ST_STALE;
              end
            end
          end else if (!has_tgt_q) begin
            status_d = rtt_pkg::ST_MISSING;
          end else if (old_r_q < tgt_q) begin
            status_d = rtt_pkg::ST_STALE;
          end else if (old_r_q == tgt_q) begin
            status_d = rtt_pkg::ST_ALREADY_CUR;
          end else begin
            status_d = rtt_pkg::ST_MISSING;
          end
        end
        rtt_pkg::REQ_CLEAR: begin
          status_d  = rtt_pkg::ST_CLEARED;
          cmd.clear = 1'b1;
          oldest_d  = '0;
          count_d   = '0;
          pend_d    = '0;
          has_tgt_d = 1'b0;
          tgt_d     = '0;
        end
        default: begin
          // unknown request: reported invalid, nothing changes
          status_d = rtt_pkg::ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q  <= '0;
      count_q   <= '0;
      pend_q    <= '0;
      has_tgt_q <= 1'b0;
      tgt_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      has_tgt_q <= has_tgt_d;
      tgt_q     <= tgt_d;
      done_q    <= in_vld_q;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      status_q   <= status_d;
      exact_q    <= exact_d;
      allow_q    <= allow_d;
      apply_q    <= apply_d;
      nxt_q      <= nxt_d;
      pend_out_q <= rtt_pkg::PendW'(pend_d);
    end
  end

  assign done_o                = done_q;
  assign status_o              = status_q;
  assign exact_match_o         = exact_q;
  assign allow_old_dir_o       = allow_q;
  assign should_apply_o        = apply_q;
  assign next_session_out_o    = nxt_q[rtt_pkg::RoundW-1:rtt_pkg::HalfW];
  assign next_generation_out_o = nxt_q[rtt_pkg::HalfW-1:0];
  assign pending_count_o       = pend_out_q;

  // every word in the input register yields exactly one result strobe next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |=> done_q)
    else $error("word in flight produced no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> !done_q)
    else $error("result strobe without a word");

  // pending entries are a subset of stored entries, which never exceed the table size
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= count_q) && (count_q <= rtt_pkg::CntW'(rtt_pkg::MaxEntries)))
    else $error("pending or entry count out of range");

  // an applied result leaves a target equal to the reported next round
  a_apply_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && apply_q) |-> (has_tgt_q && (tgt_q == nxt_q)))
    else $error("applied round does not match target");

endmodule
